FILE: rtl/core/ttcw_pkg.sv
package ttcw_pkg;

    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 128;
    localparam int TAB_STOP = 8;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int RCNT_W = ROW_W + 1;
    localparam int CCNT_W = COL_W + 1;

    localparam int CMD_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int ROWS_REG_W  = 6;
    localparam int COLS_REG_W  = 8;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    localparam logic [BYTE_W-1:0] CH_BEL   = 8'h07;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 3'd0,
        CMD_GOTO      = 3'd1,
        CMD_CLEAR_EOL = 3'd2,
        CMD_READ      = 3'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LITERAL   = 3'd0,
        REG_AUTO_WRAP = 3'd1,
        REG_CR_LF     = 3'd2,
        REG_LF_CR     = 3'd3,
        REG_BS_BLANK  = 3'd4,
        REG_ROWS      = 3'd5,
        REG_COLS      = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_NORM,
        OP_EXEC,
        OP_LF,
        OP_CLEAR,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic              literal;
        logic              auto_wrap;
        logic              cr_lf;
        logic              lf_cr;
        logic              bs_blank;
        logic [RCNT_W-1:0] rows;
        logic [CCNT_W-1:0] cols;
    } t_cfg;

    typedef struct packed {
        logic top_ok;
        logic need_lf;
        logic need_clear;
        logic do_scroll;
        logic clr_last;
        logic init_last;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/core/ttcw_ctrl.sv
module ttcw_ctrl
    import ttcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_op     o_op
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_NORM,
        ST_EXEC,
        ST_LF,
        ST_CLEAR,
        ST_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            ST_INIT: begin
                o_op = OP_INIT;
                if (i_status.init_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                // one subtraction of the row count per cycle until top is in range
                o_op = OP_NORM;
                if (i_status.top_ok) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                o_op = OP_EXEC;
                if (i_status.need_lf)         n_state = ST_LF;
                else if (i_status.need_clear) n_state = ST_CLEAR;
                else                          n_state = ST_DONE;
            end
            ST_LF: begin
                o_op    = OP_LF;
                n_state = i_status.do_scroll ? ST_CLEAR : ST_DONE;
            end
            ST_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_status.clr_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_op    = OP_EMIT;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

FILE: rtl/core/ttcw_dpath.sv
module ttcw_dpath
    import ttcw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_dp_op                 i_op,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    output t_dp_status             o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    logic [BYTE_W-1:0] r_mem [MAX_ROWS*MAX_COLS];
    logic [BYTE_W-1:0] r_mem_q;

    t_cmd              r_cmd;
    logic [BYTE_W-1:0] r_byte;
    logic [COL_W-1:0]  r_tcol;
    logic [ROW_W-1:0]  r_trow;

    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ROW_W-1:0]  r_top, n_top;
    logic [ROW_W-1:0]  r_clr_row, n_clr_row;
    logic [COL_W-1:0]  r_clr_col, n_clr_col;
    logic [ADDR_W-1:0] r_init_addr;

    logic              r_bell, n_bell;
    logic              r_scrolled, n_scrolled;
    logic              r_cell, n_cell;
    logic [COL_W-1:0]  r_cell_col, n_cell_col;
    logic [ROW_W-1:0]  r_cell_row, n_cell_row;
    logic              r_bad, n_bad;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [ROW_W-1:0]  rows_m1;
    logic [COL_W-1:0]  cols_m1;
    logic [RCNT_W-1:0] rows_m1_w;
    logic [CCNT_W-1:0] cols_m1_w;
    logic [COL_W-1:0]  tcol_sat;
    logic [ROW_W-1:0]  trow_sat;
    logic [ROW_W-1:0]  phys_cur;
    logic [ROW_W-1:0]  phys_tgt;
    logic [ROW_W-1:0]  top_inc;
    logic [CCNT_W-1:0] tab_next;
    logic [COL_W-1:0]  bs_col;
    logic              is_ctrl;
    logic              char_wr;
    logic              last_col;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    function automatic logic [ROW_W-1:0] phys_row(
        input logic [ROW_W-1:0]  top,
        input logic [ROW_W-1:0]  row,
        input logic [RCNT_W-1:0] rows
    );
        logic [RCNT_W-1:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (sum >= rows) sum = sum - rows;
        return sum[ROW_W-1:0];
    endfunction

    assign rows_m1_w = i_cfg.rows - 1'b1;
    assign cols_m1_w = i_cfg.cols - 1'b1;
    assign rows_m1   = rows_m1_w[ROW_W-1:0];
    assign cols_m1   = cols_m1_w[COL_W-1:0];

    assign tcol_sat = ({1'b0, r_tcol} >= i_cfg.cols) ? cols_m1 : r_tcol;
    assign trow_sat = ({1'b0, r_trow} >= i_cfg.rows) ? rows_m1 : r_trow;
    assign phys_cur = phys_row(r_top, r_row, i_cfg.rows);
    assign phys_tgt = phys_row(r_top, trow_sat, i_cfg.rows);
    assign top_inc  = ({1'b0, r_top} + 1'b1 >= i_cfg.rows) ? '0 : r_top + 1'b1;
    assign tab_next = CCNT_W'(({1'b0, r_col} / CCNT_W'(TAB_STOP) + 1'b1)
                              * CCNT_W'(TAB_STOP));
    assign bs_col   = (r_col == '0) ? '0 : r_col - 1'b1;
    assign last_col = ({1'b0, r_col} + 1'b1 >= i_cfg.cols);

    always_comb begin
        is_ctrl = 1'b0;
        if (!i_cfg.literal) begin
            case (r_byte)
                CH_BEL, CH_BS, CH_TAB, CH_LF, CH_CR: is_ctrl = 1'b1;
                default:                             is_ctrl = 1'b0;
            endcase
        end
    end

    assign char_wr = (r_cmd == CMD_WRITE) && !is_ctrl;

    always_comb begin
        o_status            = '0;
        o_status.top_ok     = ({1'b0, r_top} < i_cfg.rows);
        o_status.need_clear = (r_cmd == CMD_CLEAR_EOL);
        o_status.do_scroll  = ({1'b0, r_row} + 1'b1 >= i_cfg.rows);
        o_status.clr_last   = (r_clr_col == cols_m1);
        o_status.init_last  = &r_init_addr;
        o_status.out_free   = !r_out_valid || i_out_ready;
        if (r_cmd == CMD_WRITE) begin
            if (char_wr) begin
                o_status.need_lf = last_col && i_cfg.auto_wrap;
            end else begin
                case (r_byte)
                    CH_TAB:  o_status.need_lf = (tab_next >= i_cfg.cols);
                    CH_CR:   o_status.need_lf = i_cfg.cr_lf;
                    CH_LF:   o_status.need_lf = 1'b1;
                    default: o_status.need_lf = 1'b0;
                endcase
            end
        end
    end

    // next state of cursor, pointers and flags
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_top      = r_top;
        n_clr_row  = r_clr_row;
        n_clr_col  = r_clr_col;
        n_bell     = r_bell;
        n_scrolled = r_scrolled;
        n_cell     = r_cell;
        n_cell_col = r_cell_col;
        n_cell_row = r_cell_row;
        n_bad      = r_bad;
        mem_we     = 1'b0;
        mem_waddr  = r_init_addr;
        mem_wdata  = CH_SPACE;
        mem_re     = 1'b0;
        mem_raddr  = {phys_tgt, tcol_sat};
        case (i_op)
            OP_INIT: begin
                mem_we = 1'b1;
            end
            OP_LOAD: begin
                n_bell     = 1'b0;
                n_scrolled = 1'b0;
                n_cell     = 1'b0;
                n_cell_col = '0;
                n_cell_row = '0;
                n_bad      = 1'b0;
            end
            OP_NORM: begin
                if ({1'b0, r_col} >= i_cfg.cols) n_col = cols_m1;
                if ({1'b0, r_row} >= i_cfg.rows) n_row = rows_m1;
                if (!o_status.top_ok) begin
                    n_top = ROW_W'({1'b0, r_top} - i_cfg.rows);
                end
            end
            OP_EXEC: begin
                case (r_cmd)
                    CMD_WRITE: begin
                        if (char_wr) begin
                            mem_we     = 1'b1;
                            mem_waddr  = {phys_cur, r_col};
                            mem_wdata  = r_byte;
                            n_cell     = 1'b1;
                            n_cell_col = r_col;
                            n_cell_row = r_row;
                            if (!last_col)             n_col = r_col + 1'b1;
                            else if (i_cfg.auto_wrap)  n_col = '0;
                        end else begin
                            case (r_byte)
                                CH_BEL: n_bell = 1'b1;
                                CH_BS: begin
                                    n_col = bs_col;
                                    if (i_cfg.bs_blank) begin
                                        mem_we     = 1'b1;
                                        mem_waddr  = {phys_cur, bs_col};
                                        n_cell     = 1'b1;
                                        n_cell_col = bs_col;
                                        n_cell_row = r_row;
                                    end
                                end
                                CH_TAB: begin
                                    if (tab_next >= i_cfg.cols) n_col = '0;
                                    else                        n_col = tab_next[COL_W-1:0];
                                end
                                CH_CR: n_col = '0;
                                CH_LF: if (i_cfg.lf_cr) n_col = '0;
                                default: ;
                            endcase
                        end
                    end
                    CMD_GOTO: begin
                        n_col = tcol_sat;
                        n_row = trow_sat;
                    end
                    CMD_CLEAR_EOL: begin
                        n_clr_row = phys_cur;
                        n_clr_col = r_col;
                    end
                    CMD_READ: mem_re = 1'b1;
                    default:  n_bad = 1'b1;
                endcase
            end
            OP_LF: begin
                if (o_status.do_scroll) begin
                    // blank the old top row, it becomes the new bottom row
                    n_clr_row  = r_top;
                    n_clr_col  = '0;
                    n_top      = top_inc;
                    n_row      = rows_m1;
                    n_scrolled = 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            OP_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_clr_row, r_clr_col};
                n_clr_col = r_clr_col + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_mem_q <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_top       <= '0;
            r_init_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_top <= n_top;
            if (i_op == OP_INIT) r_init_addr <= r_init_addr + 1'b1;
            if (i_op == OP_EMIT)                r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clr_row  <= n_clr_row;
        r_clr_col  <= n_clr_col;
        r_bell     <= n_bell;
        r_scrolled <= n_scrolled;
        r_cell     <= n_cell;
        r_cell_col <= n_cell_col;
        r_cell_row <= n_cell_row;
        r_bad      <= n_bad;
        if (i_op == OP_LOAD) begin
            r_cmd  <= t_cmd'(i_command);
            r_byte <= i_in_data[7:0];
            r_tcol <= i_in_data[14:8];
            r_trow <= i_in_data[19:15];
        end
        if (i_op == OP_EMIT) begin
            r_out_data <= {7'd0, r_bad,
                           (r_cmd == CMD_READ) ? r_mem_q : 8'd0,
                           r_cell_row, r_cell_col, r_cell, r_scrolled, r_bell,
                           r_top, r_row, r_col};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/core/text_terminal_cell_writer_unit.sv
// Steps per transaction: normalise, execute, emit. Normalise repeats a row-count subtraction
// while the top pointer is out of range after a resize; a line feed adds a line-feed step,
// and a clear step writes one cell at a time (scroll or clear to end of line).
// A new item is taken only after the previous result has been emitted, and emit waits
// until the result side is free, so items never overlap; set by the control sequencer.
// Reset: synchronous, active low; a clearing pass then writes spaces into all 4096 cells,
// one cell per cycle, with s_axis_tready low; configuration writes are taken throughout.
module text_terminal_cell_writer_unit
    import ttcw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // byte_value[7:0], target_col[14:8], target_row[19:15], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command[2:0]
    input  logic [CMD_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // cursor_col[6:0], cursor_row[11:7], top_row[16:12], bell[17], scrolled[18],
    // cell_changed[19], changed_col[26:20], changed_row[31:27], read_char[39:32],
    // bad_command[40], zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    logic                  r_literal;
    logic                  r_auto_wrap;
    logic                  r_cr_lf;
    logic                  r_lf_cr;
    logic                  r_bs_blank;
    logic [ROWS_REG_W-1:0] r_rows;
    logic [COLS_REG_W-1:0] r_cols;

    t_cfg       cfg;
    t_dp_status status;
    t_dp_op     op;
    logic       in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_literal   <= 1'b0;
            r_auto_wrap <= 1'b1;
            r_cr_lf     <= 1'b0;
            r_lf_cr     <= 1'b1;
            r_bs_blank  <= 1'b1;
            r_rows      <= ROWS_REG_W'(25);
            r_cols      <= COLS_REG_W'(80);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_LITERAL:   r_literal   <= i_cfg_wdata[0];
                REG_AUTO_WRAP: r_auto_wrap <= i_cfg_wdata[0];
                REG_CR_LF:     r_cr_lf     <= i_cfg_wdata[0];
                REG_LF_CR:     r_lf_cr     <= i_cfg_wdata[0];
                REG_BS_BLANK:  r_bs_blank  <= i_cfg_wdata[0];
                REG_ROWS:      r_rows      <= i_cfg_wdata[ROWS_REG_W-1:0];
                REG_COLS:      r_cols      <= i_cfg_wdata[COLS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate the screen size to 1..MAX
    always_comb begin
        cfg           = '0;
        cfg.literal   = r_literal;
        cfg.auto_wrap = r_auto_wrap;
        cfg.cr_lf     = r_cr_lf;
        cfg.lf_cr     = r_lf_cr;
        cfg.bs_blank  = r_bs_blank;
        if (r_rows == '0)                         cfg.rows = RCNT_W'(1);
        else if (r_rows > ROWS_REG_W'(MAX_ROWS))  cfg.rows = RCNT_W'(MAX_ROWS);
        else                                      cfg.rows = RCNT_W'(r_rows);
        if (r_cols == '0)                         cfg.cols = CCNT_W'(1);
        else if (r_cols > COLS_REG_W'(MAX_COLS))  cfg.cols = CCNT_W'(MAX_COLS);
        else                                      cfg.cols = CCNT_W'(r_cols);
    end

    ttcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_op       (op)
    );

    ttcw_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_op        (op),
        .i_command   (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    assign s_axis_tready = in_ready;

endmodule

FILE: dv/ttcw_screen_checker.sv
module ttcw_screen_checker
    import ttcw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    // byte_value[7:0], target_col[14:8], target_row[19:15], zero fill
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    // command[2:0]
    input  logic [CMD_W-1:0]       i_in_cmd,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    // cursor_col[6:0], cursor_row[11:7], top_row[16:12], bell[17], scrolled[18],
    // cell_changed[19], changed_col[26:20], changed_row[31:27], read_char[39:32],
    // bad_command[40], zero fill
    input  logic [OUT_TDATA_W-1:0] i_out_data,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    output int                     o_mismatches,
    output int                     o_outstanding,
    output int                     o_results,
    output int                     o_scrolls
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STATUS_BITS = 2 * COL_W + 3 * ROW_W + 3 + BYTE_W + 1;
    localparam int MAX_PRINTS  = 50;

    typedef struct packed {
        logic [OUT_TDATA_W-STATUS_BITS-1:0] fill;
        logic                               bad_command;
        logic [BYTE_W-1:0]                  read_char;
        logic [ROW_W-1:0]                   changed_row;
        logic [COL_W-1:0]                   changed_col;
        logic                               cell_changed;
        logic                               scrolled;
        logic                               bell;
        logic [ROW_W-1:0]                   top_row;
        logic [ROW_W-1:0]                   cursor_row;
        logic [COL_W-1:0]                   cursor_col;
    } t_term_status;

    logic [BYTE_W-1:0] screen_cells [MAX_ROWS*MAX_COLS];
    int unsigned       cur_col, cur_line, top_ptr;
    int unsigned       n_rows, n_cols;
    bit                literal_on, wrap_on, cr_lf_on, lf_cr_on, bs_blank_on;
    int unsigned       rows_reg, cols_reg;
    bit                bell_hit, scroll_hit, cell_hit;
    int unsigned       hit_col, hit_row;

    t_term_status status_due_q [$];

    task automatic report_mismatch(string msg);
        if (o_mismatches < MAX_PRINTS)
            $display("MISMATCH at result %0d: %s", o_results, msg);
        o_mismatches++;
    endtask

    task automatic compare_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    function automatic int unsigned cell_addr(int unsigned r, int unsigned c);
        return ((top_ptr + r) % n_rows) * MAX_COLS + c;
    endfunction

    function automatic void feed_line();
        if (cur_line + 1 >= n_rows) begin
            // old top row becomes the new bottom row: blank it
            for (int c = 0; c < n_cols; c++)
                screen_cells[top_ptr * MAX_COLS + c] = CH_SPACE;
            top_ptr    = (top_ptr + 1) % n_rows;
            cur_line   = n_rows - 1;
            scroll_hit = 1'b1;
        end else begin
            cur_line++;
        end
    endfunction

    function automatic void mark_cell();
        cell_hit = 1'b1;
        hit_col  = cur_col;
        hit_row  = cur_line;
    endfunction

    function automatic void place_char(logic [BYTE_W-1:0] ch);
        screen_cells[cell_addr(cur_line, cur_col)] = ch;
        mark_cell();
        if (cur_col + 1 < n_cols) begin
            cur_col++;
        end else if (wrap_on) begin
            cur_col = 0;
            feed_line();
        end
    endfunction

    function automatic void interpret_byte(logic [BYTE_W-1:0] ch);
        if (literal_on) begin
            place_char(ch);
        end else begin
            case (ch)
                CH_BEL: bell_hit = 1'b1;
                CH_BS: begin
                    if (cur_col > 0)
                        cur_col--;
                    if (bs_blank_on) begin
                        screen_cells[cell_addr(cur_line, cur_col)] = CH_SPACE;
                        mark_cell();
                    end
                end
                CH_TAB: begin
                    cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
                    if (cur_col >= n_cols) begin
                        cur_col = 0;
                        feed_line();
                    end
                end
                CH_CR: begin
                    cur_col = 0;
                    if (cr_lf_on)
                        feed_line();
                end
                CH_LF: begin
                    if (lf_cr_on)
                        cur_col = 0;
                    feed_line();
                end
                default: place_char(ch);
            endcase
        end
    endfunction

    function automatic t_term_status advance_terminal(logic [CMD_W-1:0] cmd,
                                                      logic [BYTE_W-1:0] val,
                                                      int unsigned tcol,
                                                      int unsigned trow);
        t_term_status st;
        int unsigned  rd;
        bit           bad;
        st  = '0;
        rd  = 0;
        bad = 1'b0;
        n_rows = (rows_reg < 1) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        n_cols = (cols_reg < 1) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
        // pull cursor and top pointer back inside a shrunk screen
        if (cur_col >= n_cols)
            cur_col = n_cols - 1;
        if (cur_line >= n_rows)
            cur_line = n_rows - 1;
        top_ptr    = top_ptr % n_rows;
        bell_hit   = 1'b0;
        scroll_hit = 1'b0;
        cell_hit   = 1'b0;
        hit_col    = 0;
        hit_row    = 0;
        if (tcol >= n_cols)
            tcol = n_cols - 1;
        if (trow >= n_rows)
            trow = n_rows - 1;
        case (cmd)
            CMD_WRITE: interpret_byte(val);
            CMD_GOTO: begin
                cur_col  = tcol;
                cur_line = trow;
            end
            CMD_CLEAR_EOL: begin
                for (int unsigned c = cur_col; c < n_cols; c++)
                    screen_cells[cell_addr(cur_line, c)] = CH_SPACE;
            end
            CMD_READ: rd = screen_cells[cell_addr(trow, tcol)];
            default: bad = 1'b1;
        endcase
        st.cursor_col   = cur_col[COL_W-1:0];
        st.cursor_row   = cur_line[ROW_W-1:0];
        st.top_row      = top_ptr[ROW_W-1:0];
        st.bell         = bell_hit;
        st.scrolled     = scroll_hit;
        st.cell_changed = cell_hit;
        st.changed_col  = hit_col[COL_W-1:0];
        st.changed_row  = hit_row[ROW_W-1:0];
        st.read_char    = rd[BYTE_W-1:0];
        st.bad_command  = bad;
        return st;
    endfunction

    always @(posedge i_clk) begin
        t_term_status got;
        t_term_status want;
        if (!i_rst_n) begin
            foreach (screen_cells[k])
                screen_cells[k] = CH_SPACE;
            cur_col     = 0;
            cur_line    = 0;
            top_ptr     = 0;
            literal_on  = 1'b0;
            wrap_on     = 1'b1;
            cr_lf_on    = 1'b0;
            lf_cr_on    = 1'b1;
            bs_blank_on = 1'b1;
            rows_reg    = 25;
            cols_reg    = 80;
            status_due_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (status_due_q.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = status_due_q.pop_front();
                    compare_field("cursor_col", got.cursor_col, want.cursor_col);
                    compare_field("cursor_row", got.cursor_row, want.cursor_row);
                    compare_field("top_row", got.top_row, want.top_row);
                    compare_field("bell", got.bell, want.bell);
                    compare_field("scrolled", got.scrolled, want.scrolled);
                    compare_field("cell_changed", got.cell_changed, want.cell_changed);
                    compare_field("changed_col", got.changed_col, want.changed_col);
                    compare_field("changed_row", got.changed_row, want.changed_row);
                    compare_field("read_char", got.read_char, want.read_char);
                    compare_field("bad_command", got.bad_command, want.bad_command);
                    compare_field("zero fill", got.fill, want.fill);
                end
                o_results++;
            end
            if (i_in_valid && i_in_ready) begin
                want = advance_terminal(i_in_cmd,
                                        i_in_data[BYTE_W-1:0],
                                        i_in_data[BYTE_W+COL_W-1:BYTE_W],
                                        i_in_data[BYTE_W+COL_W+ROW_W-1:BYTE_W+COL_W]);
                o_scrolls += want.scrolled;
                status_due_q.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LITERAL:   literal_on  = i_cfg_wdata[0];
                    REG_AUTO_WRAP: wrap_on     = i_cfg_wdata[0];
                    REG_CR_LF:     cr_lf_on    = i_cfg_wdata[0];
                    REG_LF_CR:     lf_cr_on    = i_cfg_wdata[0];
                    REG_BS_BLANK:  bs_blank_on = i_cfg_wdata[0];
                    REG_ROWS:      rows_reg    = i_cfg_wdata[ROWS_REG_W-1:0];
                    REG_COLS:      cols_reg    = i_cfg_wdata[COLS_REG_W-1:0];
                    default: ;
                endcase
            end
        end
        o_outstanding = status_due_q.size();
    end

endmodule

FILE: dv/text_terminal_cell_writer_unit_tb.sv
module text_terminal_cell_writer_unit_tb
    import ttcw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNDEF_FIRST = 3'd4;
    localparam logic [CMD_W-1:0] CMD_UNDEF_LAST  = 3'd7;
    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 75;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 20;

    typedef struct {
        bit                      literal_on;
        bit                      wrap_on;
        bit                      cr_lf_on;
        bit                      lf_cr_on;
        bit                      bs_blank_on;
        logic [ROWS_REG_W-1:0]   rows;
        logic [COLS_REG_W-1:0]   cols;
    } t_screen_setup;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_wdata;

    int mismatches, outstanding, results, scrolls;
    int items_sent;
    int setups_used;
    int vis_rows, vis_cols;
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold_left;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    text_terminal_cell_writer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    ttcw_screen_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_cmd      (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_results     (results),
        .o_scrolls     (scrolls)
    );

    initial begin
        #2_000_000;
        $display("[text_terminal_cell_writer_unit] ERROR");
        $finish;
    end

    // result side: random back-pressure, or a counted hold-off when asked
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < 36);
            end
        end
    end

    task automatic offer_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] val,
                              logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        bit taken;
        while (tx_idle_on && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-BYTE_W-COL_W-ROW_W){1'b0}}, row, col, val};
        s_axis_tuser  <= cmd;
        // ready is settled by the falling edge; the transaction lands on the next rise
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge i_clk);
        while (outstanding != 0);
        @(posedge i_clk);
    endtask

    task automatic put_reg(t_reg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_setup(t_screen_setup s);
        wait_drained();
        put_reg(REG_LITERAL, CFG_W'(s.literal_on));
        put_reg(REG_AUTO_WRAP, CFG_W'(s.wrap_on));
        put_reg(REG_CR_LF, CFG_W'(s.cr_lf_on));
        put_reg(REG_LF_CR, CFG_W'(s.lf_cr_on));
        put_reg(REG_BS_BLANK, CFG_W'(s.bs_blank_on));
        put_reg(REG_ROWS, CFG_W'(s.rows));
        put_reg(REG_COLS, s.cols);
        i_cfg_we <= 1'b0;
        vis_rows = (s.rows < 1) ? 1 : (s.rows > MAX_ROWS) ? MAX_ROWS : s.rows;
        vis_cols = (s.cols < 1) ? 1 : (s.cols > MAX_COLS) ? MAX_COLS : s.cols;
        setups_used++;
    endtask

    task automatic offer_random();
        int                pick;
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] val;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        pick = $urandom_range(0, 99);
        cmd  = CMD_WRITE;
        val  = BYTE_W'($urandom);
        col  = COL_W'($urandom);
        row  = ROW_W'($urandom);
        if (pick < 40) begin
            val = BYTE_W'($urandom_range(8'h21, 8'h7E));
        end else if (pick < 58) begin
            case ($urandom_range(0, 5))
                0: val = CH_BEL;
                1: val = CH_BS;
                2: val = CH_TAB;
                3: val = CH_CR;
                default: val = CH_LF;
            endcase
        end else if (pick < 66) begin
            cmd = CMD_WRITE;
        end else if (pick < 96) begin
            if (pick < 78)
                cmd = CMD_GOTO;
            else if (pick < 84)
                cmd = CMD_CLEAR_EOL;
            else
                cmd = CMD_READ;
            // mostly aim inside the screen, often at the last row or column
            if ($urandom_range(0, 99) < 75) begin
                col = COL_W'($urandom_range(0, vis_cols - 1));
                row = ROW_W'($urandom_range(0, vis_rows - 1));
                if ($urandom_range(0, 2) == 0)
                    row = ROW_W'(vis_rows - 1);
                if ($urandom_range(0, 4) == 0)
                    col = COL_W'(vis_cols - 1);
            end
        end else begin
            cmd = CMD_W'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
        end
        offer_item(cmd, val, col, row);
    endtask

    initial begin
        t_screen_setup setup;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_WRITE;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_LITERAL;
        i_cfg_wdata   <= '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        rx_hold_left  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass on the power-up screen
        setup = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 6'd25, 8'd80};
        apply_setup(setup);
        offer_item(CMD_WRITE, "A", '1, '1);
        offer_item(CMD_WRITE, 8'h00, '0, '0);
        offer_item(CMD_WRITE, 8'hFF, '1, '0);
        offer_item(CMD_WRITE, CH_BEL, '0, '0);
        offer_item(CMD_WRITE, CH_BS, '0, '0);
        offer_item(CMD_GOTO, 8'h00, '0, '0);
        offer_item(CMD_WRITE, CH_BS, '0, '0);
        offer_item(CMD_WRITE, CH_TAB, '0, '0);
        offer_item(CMD_WRITE, CH_CR, '0, '0);
        offer_item(CMD_WRITE, CH_LF, '0, '0);
        offer_item(CMD_GOTO, 8'h00, '1, '1);
        offer_item(CMD_WRITE, "Z", '0, '0);
        offer_item(CMD_GOTO, 8'h00, 7'd76, 5'd3);
        offer_item(CMD_WRITE, CH_TAB, '0, '0);
        offer_item(CMD_GOTO, 8'h00, 7'd5, 5'd3);
        offer_item(CMD_CLEAR_EOL, 8'h00, '0, '0);
        offer_item(CMD_READ, 8'h00, '0, '0);
        offer_item(CMD_READ, 8'h00, '1, '1);
        offer_item(CMD_READ, 8'h00, 7'd1, 5'd0);
        for (int k = CMD_UNDEF_FIRST; k <= CMD_UNDEF_LAST; k++)
            offer_item(k[CMD_W-1:0], 8'hFF, '1, '1);
        offer_item(CMD_GOTO, 8'h00, '0, 5'd24);
        offer_item(CMD_WRITE, CH_LF, '0, '0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: setup = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 6'd3, 8'd10};
                1: setup = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 6'd0, 8'd0};
                2: setup = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 6'd63, 8'd255};
                3: setup = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 6'd1, 8'd128};
                4: setup = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd32, 8'd1};
                default: begin
                    setup.literal_on  = ($urandom_range(0, 3) == 0);
                    setup.wrap_on     = 1'($urandom);
                    setup.cr_lf_on    = 1'($urandom);
                    setup.lf_cr_on    = 1'($urandom);
                    setup.bs_blank_on = 1'($urandom);
                    setup.rows = ROWS_REG_W'(($urandom_range(0, 1) != 0)
                                             ? $urandom_range(1, 6)
                                             : $urandom_range(0, 63));
                    setup.cols = COLS_REG_W'(($urandom_range(0, 1) != 0)
                                             ? $urandom_range(1, 20)
                                             : $urandom_range(0, 255));
                end
            endcase
            apply_setup(setup);
            if (p == 5) begin
                // stall results while items keep coming so the input backs up
                tx_idle_on   = 1'b0;
                rx_hold_left = HOLD_LEN;
            end
            if (p == 6) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (p == 5 && k == 40)
                    tx_idle_on = 1'b1;
                if (p == 7 && k == PHASE_LEN / 2)
                    wait_drained();
                offer_random();
            end
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Sent %0d terminal commands, compared %0d results over %0d screen setups.",
                 items_sent, results, setups_used);
        $display("Screen scrolled %0d times; back-pressure hold-off and full drains included.",
                 scrolls);
        if (mismatches == 0)
            $display("[text_terminal_cell_writer_unit] OK");
        else
            $display("[text_terminal_cell_writer_unit] ERROR");
        $finish;
    end

endmodule
